// ===== hw/rtl/asas_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC scan averaging sequencer package
// Widths shared by the sequencer top level and its serial divider, plus the
// register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package asas_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int CHAN_W     = 3;
	localparam int CHANNELS   = 8;
	localparam int SUM_W      = 18;
	localparam int CC_W       = 4;
	localparam int AC_W       = 8;
	localparam int RND_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ADD,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ===== hw/rtl/asas_divider.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// Divides the channel sum by the averaging count, one quotient bit per cycle,
// MSB first, with a narrow remainder register.
// ----------------------------------------------------------------------------
module asas_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [asas_pkg::SUM_W-1:0]    dividend,
	input  logic [asas_pkg::AC_W-1:0]     divisor,
	output logic                          done,
	output logic [asas_pkg::SUM_W-1:0]    quotient
);

	logic [asas_pkg::SUM_W-1:0]     quo_q;
	logic [asas_pkg::AC_W-1:0]      rem_q;
	logic [asas_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [asas_pkg::AC_W:0]        trial;
	logic                           q_bit;

	// The dividend shifts out at the top while quotient bits shift in below.
	assign trial = {rem_q, quo_q[asas_pkg::SUM_W-1]};
	assign q_bit = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= asas_pkg::DIV_CNT_W'(asas_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == asas_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[asas_pkg::SUM_W-2:0], q_bit};
			if (q_bit) begin
				rem_q <= asas_pkg::AC_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[asas_pkg::AC_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/adc_scan_averaging_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ADC scan averaging sequencer
// Steps an ADC round-robin over the enabled channels, accumulates each
// channel's samples over a sweep and reports the per-channel average.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                   Payload
// -------   -------------------------   ----------------------------------------
// sample    sample_valid / sample_stall sample
// result    result_valid / result_stall channel, average, average_valid,
//                                       sweep_done, next_channel
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An item that does not end its channel's sweep passes from accept to result
// through the states READ, ADD and FIN: one memory read, one add and
// write-back, one step to load the output register. An item in the last round
// also runs the serial divider between ADD and FIN, which produces one quotient
// bit per cycle over the 18-bit sum. The next item is accepted once the
// previous one has moved into the output register, even while that result is
// still stalled. Reset clears the scan position, the round counter and the
// output valid and sets the configuration to one channel and one round; the
// accumulator memory is not cleared because round 0 starts each sum from zero.
//
module adc_scan_averaging_sequencer_unit (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [asas_pkg::SAMPLE_W-1:0]      sample,

	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [asas_pkg::CHAN_W-1:0]        channel,
	output logic [asas_pkg::SAMPLE_W-1:0]      average,
	output logic                               average_valid,
	output logic                               sweep_done,
	output logic [asas_pkg::CHAN_W-1:0]        next_channel,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [asas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asas_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [asas_pkg::CC_W-1:0]     channel_count_q;
	logic [asas_pkg::AC_W-1:0]     average_count_q;

	// Scan position.
	logic [asas_pkg::CHAN_W-1:0]   cur_chan_q;
	logic [asas_pkg::RND_W-1:0]    round_q;

	// Item being worked on.
	asas_pkg::state_t              state_q, state_d;
	logic [asas_pkg::SAMPLE_W-1:0] sample_q;
	logic [asas_pkg::CHAN_W-1:0]   ch_q;
	logic [asas_pkg::CHAN_W-1:0]   nxt_ch_q;
	logic                          first_q;
	logic                          last_q;
	logic                          done_q;
	logic [asas_pkg::SUM_W-1:0]    rd_q;

	// Accumulator memory, one sum per channel.
	logic [asas_pkg::SUM_W-1:0]    sum_mem_q [asas_pkg::CHANNELS];

	// Output register.
	logic                          res_valid_q;
	logic [asas_pkg::CHAN_W-1:0]   res_chan_q;
	logic [asas_pkg::SAMPLE_W-1:0] res_avg_q;
	logic                          res_avg_valid_q;
	logic                          res_done_q;
	logic [asas_pkg::CHAN_W-1:0]   res_next_q;

	logic                          accept;
	logic [asas_pkg::CC_W-1:0]     eff_chans;
	logic [asas_pkg::AC_W-1:0]     eff_avg;
	logic [asas_pkg::CC_W-1:0]     chan_inc;
	logic                          chan_wrap;
	logic [asas_pkg::RND_W:0]      round_inc;
	logic                          round_wrap;
	logic                          mem_we;
	logic [asas_pkg::SUM_W-1:0]    mem_wdata;
	logic [asas_pkg::SUM_W-1:0]    sum_c;
	logic                          div_start;
	logic                          div_done;
	logic [asas_pkg::SUM_W-1:0]    div_quo;
	logic [asas_pkg::SAMPLE_W-1:0] avg_c;
	logic                          out_load;

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != asas_pkg::ST_IDLE);
	assign accept       = sample_valid && !sample_stall;

	// A zero count acts as one; more channels than exist are clipped.
	always_comb begin
		if (channel_count_q == '0) begin
			eff_chans = asas_pkg::CC_W'(1);
		end else if (channel_count_q > asas_pkg::CC_W'(asas_pkg::CHANNELS)) begin
			eff_chans = asas_pkg::CC_W'(asas_pkg::CHANNELS);
		end else begin
			eff_chans = channel_count_q;
		end
		eff_avg = (average_count_q == '0) ? asas_pkg::AC_W'(1) : average_count_q;
	end

	// Scan stepping, decided at accept time. A channel at or past the count
	// (the count was lowered mid-sweep) still ends the round.
	assign chan_inc   = {1'b0, cur_chan_q} + 1'b1;
	assign chan_wrap  = (chan_inc >= eff_chans);
	assign round_inc  = {1'b0, round_q} + 1'b1;
	assign round_wrap = (round_inc >= {1'b0, eff_avg});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= asas_pkg::CC_W'(1);
			average_count_q <= asas_pkg::AC_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				asas_pkg::REG_CHANNEL_COUNT: begin
					channel_count_q <= cfg_data[asas_pkg::CC_W-1:0];
				end
				asas_pkg::REG_AVERAGE_COUNT: begin
					average_count_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_chan_q <= '0;
			round_q    <= '0;
		end else if (accept) begin
			if (chan_wrap) begin
				cur_chan_q <= '0;
				round_q    <= round_wrap ? '0 : round_inc[asas_pkg::RND_W-1:0];
			end else begin
				cur_chan_q <= chan_inc[asas_pkg::CHAN_W-1:0];
			end
		end
	end

	// Per-item context. The user must not change the configuration while an item is in
	// flight; the block does not enforce this. The divisor is read live, not here.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			ch_q     <= cur_chan_q;
			nxt_ch_q <= chan_wrap ? '0 : chan_inc[asas_pkg::CHAN_W-1:0];
			first_q  <= (round_q == '0);
			last_q   <= (round_q == eff_avg - 1'b1);
			done_q   <= chan_wrap && round_wrap;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sum_mem_q[ch_q] <= mem_wdata;
		end
		rd_q <= sum_mem_q[ch_q];
	end

	// The first round starts the sum from zero instead of the stored entry.
	assign sum_c = (first_q ? '0 : rd_q) + asas_pkg::SUM_W'(sample_q);

	asas_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_c),
		.divisor  (eff_avg),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Averages saturate at full scale.
	assign avg_c = (div_quo[asas_pkg::SUM_W-1:asas_pkg::SAMPLE_W] != '0) ?
		asas_pkg::SAMPLE_MAX : div_quo[asas_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wdata = sum_c;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			asas_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = asas_pkg::ST_READ;
				end
			end
			asas_pkg::ST_READ: begin
				state_d = asas_pkg::ST_ADD;
			end
			asas_pkg::ST_ADD: begin
				if (last_q) begin
					div_start = 1'b1;
					state_d   = asas_pkg::ST_DIV;
				end else begin
					mem_we  = 1'b1;
					state_d = asas_pkg::ST_FIN;
				end
			end
			asas_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = asas_pkg::ST_FIN;
				end
			end
			asas_pkg::ST_FIN: begin
				// The finished sweep leaves the average in the entry.
				if (!res_valid_q || !result_stall) begin
					out_load  = 1'b1;
					mem_we    = last_q;
					mem_wdata = asas_pkg::SUM_W'(avg_c);
					state_d   = asas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = asas_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_chan_q      <= ch_q;
			res_avg_q       <= last_q ? avg_c : '0;
			res_avg_valid_q <= last_q;
			res_done_q      <= done_q;
			res_next_q      <= nxt_ch_q;
		end
	end

	assign result_valid  = res_valid_q;
	assign channel       = res_chan_q;
	assign average       = res_avg_q;
	assign average_valid = res_avg_valid_q;
	assign sweep_done    = res_done_q;
	assign next_channel  = res_next_q;

`ifndef NO_ASSERTIONS
	// A new result only ever comes from the finishing step.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> $past(state_q == asas_pkg::ST_FIN || state_q == asas_pkg::ST_DIV ||
			state_q == asas_pkg::ST_ADD))
		else $error("result loaded outside the finishing step");

	// The divider reports completion only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == asas_pkg::ST_DIV))
		else $error("divider finished outside the divide step");

	// A result without a completed average carries a zero average.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !average_valid) |-> (average == '0))
		else $error("average set on a result without a completed average");

	// An item is taken only when the sequencer is idle, and it starts the memory read.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == asas_pkg::ST_READ))
		else $error("accepted item did not start the memory read");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// ADC scan averaging sequencer testbench
// Feeds conversion items to the sequencer and checks every result item
// against a cycle-free model of the round-robin scan with its per-channel
// accumulators. Register settings change between phases, including changes
// in the middle of a sweep. Both handshakes idle at random, and the result
// side holds off for one long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;

	// One result item of the sequencer, in port order.
	typedef struct packed {
		logic [asas_pkg::CHAN_W-1:0]   channel;
		logic [asas_pkg::SAMPLE_W-1:0] average;
		logic                          average_valid;
		logic                          sweep_done;
		logic [asas_pkg::CHAN_W-1:0]   next_channel;
	} scan_report_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;

	logic                            sample_valid = 1'b0;
	logic                            sample_stall;
	logic [asas_pkg::SAMPLE_W-1:0]   sample = '0;

	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic [asas_pkg::CHAN_W-1:0]     channel;
	logic [asas_pkg::SAMPLE_W-1:0]   average;
	logic                            average_valid;
	logic                            sweep_done;
	logic [asas_pkg::CHAN_W-1:0]     next_channel;

	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [asas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [asas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	adc_scan_averaging_sequencer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.channel       (channel),
		.average       (average),
		.average_valid (average_valid),
		.sweep_done    (sweep_done),
		.next_channel  (next_channel),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is applied once at time zero and then released for good.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Nothing in a correct run comes close to this; it only catches a hang.
	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Scan model. These mirror the block's registers and sequencing state
	// as they stand after reset. The accumulators start at zero here, but
	// the stimulus never adds to an entry outside round 0 before that entry
	// has been written, so the start value never shows in a result.
	// ------------------------------------------------------------------
	logic [asas_pkg::CC_W-1:0]   chan_count_reg = 4'd1;
	logic [asas_pkg::AC_W-1:0]   avg_count_reg = 8'd1;
	logic [asas_pkg::CHAN_W-1:0] scan_chan = '0;
	logic [asas_pkg::RND_W-1:0]  scan_round = '0;
	logic [asas_pkg::SUM_W-1:0]  chan_acc [asas_pkg::CHANNELS];

	initial begin
		for (int k = 0; k < asas_pkg::CHANNELS; k++)
			chan_acc[k] = '0;
	end

	// Takes one conversion for the selected channel, moves the scan on and
	// returns the result item that the block should give for it.
	function automatic scan_report_t next_scan_report(
		input logic [asas_pkg::SAMPLE_W-1:0] smp);
		int unsigned  live_chans;
		int unsigned  rounds;
		int unsigned  quot;
		logic [3:0]   step_to;
		scan_report_t rep;

		// A zero count acts as one; more channels than exist act as all of them.
		live_chans = (chan_count_reg == 0) ? 1 :
			((chan_count_reg > asas_pkg::CHANNELS) ? asas_pkg::CHANNELS : chan_count_reg);
		rounds = (avg_count_reg == 0) ? 1 : avg_count_reg;

		rep = '0;
		rep.channel = scan_chan;

		// Round 0 restarts the sum; the sum itself wraps at its width.
		if (scan_round == 0)
			chan_acc[scan_chan] = '0;
		chan_acc[scan_chan] = chan_acc[scan_chan] + smp;

		// Only the exact last round divides. A round above it, left over
		// after the count was lowered mid-sweep, gives no average.
		if (scan_round == rounds - 1) begin
			quot = chan_acc[scan_chan] / rounds;
			if (quot > asas_pkg::SAMPLE_MAX)
				quot = asas_pkg::SAMPLE_MAX;
			chan_acc[scan_chan] = quot[asas_pkg::SUM_W-1:0];
			rep.average = quot[asas_pkg::SAMPLE_W-1:0];
			rep.average_valid = 1'b1;
		end

		// A channel at or above the live count still got its sample, and
		// then the scan wraps and closes the round like the last channel.
		step_to = scan_chan + 1;
		if (step_to >= live_chans) begin
			step_to = '0;
			if (scan_round + 1 >= rounds) begin
				scan_round = '0;
				rep.sweep_done = 1'b1;
			end else begin
				scan_round = scan_round + 1;
			end
		end
		scan_chan = step_to[asas_pkg::CHAN_W-1:0];
		rep.next_channel = scan_chan;
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Sample side. The stimulus process fills sample_fifo; this block offers
	// one item at a time, in bursts with random gaps between them, and holds
	// the item steady while the block stalls it. Each accepted item is run
	// through the model at once and its result item joins due_reports.
	// ------------------------------------------------------------------
	logic [asas_pkg::SAMPLE_W-1:0] sample_fifo [$];
	scan_report_t                  due_reports [$];
	int unsigned                   gap_left = 0;
	int unsigned                   burst_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (sample_valid && !sample_stall)
				due_reports.push_back(next_scan_report(sample));

			if (!sample_valid || !sample_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					sample_valid <= 1'b0;
				end else if (sample_fifo.size() != 0) begin
					sample <= sample_fifo.pop_front();
					sample_valid <= 1'b1;
					// At the end of a burst pick the next burst and the gap
					// before it. A quarter of the bursts follow with no gap.
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side. Every accepted result item is checked against the oldest
	// one the model has produced. The stall follows a pattern whose mode is
	// picked at random, from never stalling to mostly stalling. Once, while
	// plenty of items are still queued, it holds off for a long stretch so
	// that the output register and the pipeline fill and the block has to
	// stall the sample side.
	// ------------------------------------------------------------------
	int unsigned  fail_count = 0;
	int unsigned  reports_seen = 0;
	int unsigned  hold_left = 0;
	logic         hold_done = 1'b0;
	int unsigned  stall_mode = 0;
	int unsigned  mode_left = 0;
	scan_report_t got_report;
	scan_report_t want_report;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				reports_seen <= reports_seen + 1;
				got_report = '{channel, average, average_valid, sweep_done, next_channel};
				if (due_reports.size() == 0) begin
					fail_count <= fail_count + 1;
					$write("%0t: result item with none due: ", $time);
					$display("ch=%0d avg=%0d v=%0b done=%0b next=%0d",
						channel, average, average_valid, sweep_done, next_channel);
				end else begin
					want_report = due_reports.pop_front();
					if (got_report !== want_report) begin
						fail_count <= fail_count + 1;
						$write("%0t: mismatch: expected ch=%0d avg=%0d v=%0b done=%0b next=%0d",
							$time, want_report.channel, want_report.average,
							want_report.average_valid, want_report.sweep_done,
							want_report.next_channel);
						$display(", actual ch=%0d avg=%0d v=%0b done=%0b next=%0d",
							got_report.channel, got_report.average,
							got_report.average_valid, got_report.sweep_done,
							got_report.next_channel);
					end
				end
			end

			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (!hold_done && reports_seen >= 40 && sample_fifo.size() > 8) begin
				hold_left <= 300;
				hold_done <= 1'b1;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 3);
					mode_left <= $urandom_range(10, 80);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= $urandom_range(0, 1);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= mode_left[2];
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and register access.
	// ------------------------------------------------------------------

	// Returns once every queued item has been taken and every result item
	// has come back. The check runs on falling edges, where the sample and
	// result sides have settled, and the task returns on one so that the
	// next pushes stay clear of the sample side's rising-edge work.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_fifo.size() != 0 || sample_valid || due_reports.size() != 0);
	endtask

	// Writes one register and updates the model's copy once it is taken.
	// Only ever called with the block idle.
	task automatic write_reg(input logic [asas_pkg::CFG_IDX_W-1:0] idx,
		input logic [asas_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == asas_pkg::REG_CHANNEL_COUNT)
			chan_count_reg = val[asas_pkg::CC_W-1:0];
		else
			avg_count_reg = val[asas_pkg::AC_W-1:0];
	endtask

	initial begin
		int unsigned               random_sent;
		int unsigned               len;
		logic [3:0]                count_sel;
		logic [3:0]                upper_bits;
		logic [asas_pkg::AC_W-1:0] rounds_sel;

		@(posedge arst_n);
		@(negedge clk);

		// Reset settings, one channel and one round: every item is a whole
		// sweep and its average is the sample itself. Both extremes.
		sample_fifo.push_back(10'd0);
		sample_fifo.push_back(10'd1023);
		wait_idle();

		// Zero channel count and zero average count both act as one.
		write_reg(asas_pkg::REG_CHANNEL_COUNT, 8'h00);
		write_reg(asas_pkg::REG_AVERAGE_COUNT, 8'h00);
		sample_fifo.push_back(10'h155);
		sample_fifo.push_back(10'h2AA);
		wait_idle();

		// A channel count of 15 acts as all eight channels; the upper data
		// bits are ignored. One round over all channels writes every
		// accumulator, so later mid-sweep changes never read a blank entry.
		write_reg(asas_pkg::REG_CHANNEL_COUNT, 8'hFF);
		write_reg(asas_pkg::REG_AVERAGE_COUNT, 8'd1);
		sample_fifo.push_back(10'd1023);
		sample_fifo.push_back(10'd0);
		sample_fifo.push_back(10'd1023);
		sample_fifo.push_back(10'h200);
		sample_fifo.push_back(10'h001);
		sample_fifo.push_back(10'h3FE);
		sample_fifo.push_back(10'h0F0);
		sample_fifo.push_back(10'h30F);
		wait_idle();

		// Three channels over three rounds, stopped after the first item of
		// round 1. Dropping the round count to one then leaves the scan in a
		// round above the last one: no average, and the round end closes
		// the sweep.
		write_reg(asas_pkg::REG_CHANNEL_COUNT, 8'd3);
		write_reg(asas_pkg::REG_AVERAGE_COUNT, 8'd3);
		repeat (4) sample_fifo.push_back($urandom_range(0, 1023));
		wait_idle();
		write_reg(asas_pkg::REG_AVERAGE_COUNT, 8'd1);
		repeat (2) sample_fifo.push_back($urandom_range(0, 1023));
		wait_idle();

		// Two rounds, stopped on channel 2. Lowering the channel count to
		// one leaves the scan beyond the count: channel 2 still takes its
		// sample, then the scan wraps to channel 0 and ends the round. The
		// next item closes the sweep from a clean boundary.
		write_reg(asas_pkg::REG_AVERAGE_COUNT, 8'd2);
		repeat (2) sample_fifo.push_back($urandom_range(0, 1023));
		wait_idle();
		write_reg(asas_pkg::REG_CHANNEL_COUNT, 8'd1);
		repeat (2) sample_fifo.push_back($urandom_range(0, 1023));
		wait_idle();

		// One full sweep at the largest round count with high samples, which
		// drives the sum close to the top of the accumulator.
		write_reg(asas_pkg::REG_AVERAGE_COUNT, 8'd255);
		for (int k = 0; k < 255; k++)
			sample_fifo.push_back(($urandom_range(0, 3) == 0) ? 10'd1023 : $urandom_range(960, 1023));
		random_sent = 255;

		// Random phases. Between phases either register may change, often in
		// the middle of a sweep, so rounds and channels left above a lowered
		// count keep coming up. Round counts stay small most of the time so
		// that sweeps finish and averages come out regularly.
		while (random_sent < 450) begin
			wait_idle();
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: count_sel = 4'd0;
					1: count_sel = 4'd1;
					2: count_sel = 4'd8;
					3: count_sel = 4'd15;
					default: count_sel = $urandom_range(1, 8);
				endcase
				upper_bits = $urandom_range(0, 15);
				write_reg(asas_pkg::REG_CHANNEL_COUNT, {upper_bits, count_sel});
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: rounds_sel = 8'd0;
					1: rounds_sel = 8'd1;
					2: rounds_sel = 8'd255;
					3: rounds_sel = $urandom_range(7, 40);
					default: rounds_sel = $urandom_range(2, 6);
				endcase
				write_reg(asas_pkg::REG_AVERAGE_COUNT, rounds_sel);
			end
			len = $urandom_range(4, 50);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 9))
					0: sample_fifo.push_back(10'd0);
					1: sample_fifo.push_back(10'd1023);
					default: sample_fifo.push_back($urandom_range(0, 1023));
				endcase
			end
			random_sent += len;
		end

		// Drain, then leave room for a stray late result item to show up.
		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && due_reports.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
